>>> rtl/core/awm_pkg.sv
// Shared types, widths and helpers for the affine warp address generator.
// Depends on nothing; every module of the block refers to it by scoped names.
`default_nettype none

package awm_pkg;

  // Coordinate and fixed-point format.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Register widths.
  localparam int COEF_W    = 24;
  localparam int OFF_W     = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;

  // Datapath widths, derived from the formats above.
  localparam int CENT_W = COORD_BITS + 1;       // centered destination coordinate
  localparam int PROD_W = COEF_W + CENT_W;      // one coefficient product
  localparam int LIN_W  = PROD_W + 1;           // sum of the two products
  localparam int T_W    = LIN_W - FRAC_BITS;    // linear part as an integer
  localparam int OFFH_W = OFF_W - FRAC_BITS;    // integer part of the offset
  localparam int U_W    = T_W + 1;              // integer part after the offset
  localparam int K_W    = U_W + 1;              // source coordinate, unsaturated
  localparam int OUT_W  = COORD_BITS + 1;       // saturated output coordinate

  localparam logic signed [K_W-1:0] K_HI = K_W'((64'sd1 <<< COORD_BITS) - 64'sd1);
  localparam logic signed [K_W-1:0] K_LO = -K_HI - K_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FROM_X      = CFG_IDX_W'(0),
    REG_X_FROM_Y      = CFG_IDX_W'(1),
    REG_X_OFFSET      = CFG_IDX_W'(2),
    REG_Y_FROM_X      = CFG_IDX_W'(3),
    REG_Y_FROM_Y      = CFG_IDX_W'(4),
    REG_Y_OFFSET      = CFG_IDX_W'(5),
    REG_IMAGE_SIZES   = CFG_IDX_W'(6),
    REG_WINDOW_BOUNDS = CFG_IDX_W'(7)
  } cfg_reg_t;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< FRAC_BITS);

  // Load enables for the per-axis datapath stages.
  typedef struct packed {
    logic prod;
    logic lin;
    logic vhi;
    logic coord;
  } stage_en_t;

  // Packed size or bound field; a field that starts beyond bit 63 reads as zero.
  function automatic logic [COORD_BITS-1:0] pack_field(input logic [CFG_W-1:0] r,
                                                       input int unsigned idx);
    logic [CFG_W-1:0] s;
    s = r >> (idx * COORD_BITS);
    return s[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/awm_axis.sv
// One axis of the affine map: two products, truncation, offset and half size.
// Four register stages; uses awm_pkg for widths and the stage enable struct.
`default_nettype none

module awm_axis (
  input  wire logic                              clk,
  input  wire awm_pkg::stage_en_t                en,
  input  wire logic signed [awm_pkg::COEF_W-1:0] ca,
  input  wire logic signed [awm_pkg::COEF_W-1:0] cb,
  input  wire logic signed [awm_pkg::OFF_W-1:0]  off,
  input  wire logic signed [awm_pkg::CENT_W-1:0] xc,
  input  wire logic signed [awm_pkg::CENT_W-1:0] yc,
  input  wire logic [awm_pkg::COORD_BITS-1:0]    half_src,
  output logic signed [awm_pkg::K_W-1:0]         coord
);

  logic signed [awm_pkg::PROD_W-1:0] prod_a;
  logic signed [awm_pkg::PROD_W-1:0] prod_b;
  logic signed [awm_pkg::LIN_W-1:0]  lin;
  logic signed [awm_pkg::U_W-1:0]    vhi;

  logic signed [awm_pkg::PROD_W-1:0] prod_a_next;
  logic signed [awm_pkg::PROD_W-1:0] prod_b_next;
  logic signed [awm_pkg::LIN_W-1:0]  lin_next;
  logic signed [awm_pkg::T_W-1:0]    t_floor;
  logic                              t_adj;
  logic signed [awm_pkg::OFFH_W-1:0] off_hi;
  logic                              off_lo_nz;
  logic signed [awm_pkg::U_W-1:0]    vhi_next;
  logic                              u_adj;
  logic signed [awm_pkg::K_W-1:0]    coord_next;

  always_comb begin
    prod_a_next = ca * xc;
    prod_b_next = cb * yc;
    lin_next    = awm_pkg::LIN_W'(prod_a) + awm_pkg::LIN_W'(prod_b);

    // Truncation toward zero is the floor plus one for a negative value with
    // fraction bits set. The offset's fraction bits do not disturb the integer
    // part of t * 2^F + offset, so only its integer part is added here.
    t_floor   = $signed(lin[awm_pkg::LIN_W-1:awm_pkg::FRAC_BITS]);
    t_adj     = lin[awm_pkg::LIN_W-1] && (|lin[awm_pkg::FRAC_BITS-1:0]);
    off_hi    = $signed(off[awm_pkg::OFF_W-1:awm_pkg::FRAC_BITS]);
    off_lo_nz = |off[awm_pkg::FRAC_BITS-1:0];
    vhi_next  = awm_pkg::U_W'(t_floor) + awm_pkg::U_W'(off_hi) + awm_pkg::U_W'(t_adj);

    // The sum is negative exactly when its integer part is; the second
    // truncation then rounds up when the offset brought fraction bits.
    u_adj      = vhi[awm_pkg::U_W-1] && off_lo_nz;
    coord_next = awm_pkg::K_W'(vhi) + awm_pkg::K_W'({1'b0, half_src})
               + awm_pkg::K_W'(u_adj);
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      prod_a <= prod_a_next;
      prod_b <= prod_b_next;
    end
    if (en.lin) begin
      lin <= lin_next;
    end
    if (en.vhi) begin
      vhi <= vhi_next;
    end
    if (en.coord) begin
      coord <= coord_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/affine_warp_nearest_map_roi_top.sv
// Top level of the affine warp address generator: config registers, pipeline
// control, centering, output saturation and window test. Uses awm_pkg, awm_axis.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one destination pixel item,
//   dest_x and dest_y. An item outside the destination size is dropped at
//   acceptance and gives no result. Every other item gives one result item on
//   the output channel (out_valid/out_ready): source_x, source_y, inside_res.
//   The pipeline has six register stages, with two multipliers per axis in
//   the product stage; while the output does not stall it takes one item per
//   cycle. Each stage loads when it is empty or the stage after it moves, so
//   a stalled receiver holds only the output register and the pipeline keeps
//   taking items until every stage is full; in_ready then falls.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; an index beyond the register list is ignored. The user must
//   change registers only while no item is in flight; it is not enforced.
//   Reset empties the pipeline and loads the identity map with all sizes and
//   bounds zero, so every item is dropped until image_sizes is written.
`default_nettype none

module affine_warp_nearest_map_roi_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [awm_pkg::COORD_BITS-1:0]       dest_x,
  input  wire logic [awm_pkg::COORD_BITS-1:0]       dest_y,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [awm_pkg::OUT_W-1:0]          source_x,
  output logic signed [awm_pkg::OUT_W-1:0]          source_y,
  output logic                                      inside_res,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [awm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [awm_pkg::CFG_W-1:0]            cfg_data
);

  localparam int NSTG = 6;

  // Configuration registers.
  logic signed [awm_pkg::COEF_W-1:0] x_from_x;
  logic signed [awm_pkg::COEF_W-1:0] x_from_y;
  logic signed [awm_pkg::OFF_W-1:0]  x_offset;
  logic signed [awm_pkg::COEF_W-1:0] y_from_x;
  logic signed [awm_pkg::COEF_W-1:0] y_from_y;
  logic signed [awm_pkg::OFF_W-1:0]  y_offset;
  logic [awm_pkg::CFG_W-1:0]         image_sizes;
  logic [awm_pkg::CFG_W-1:0]         window_bounds;

  logic [awm_pkg::COORD_BITS-1:0] dest_w, dest_h, src_w, src_h;
  logic [awm_pkg::COORD_BITS-1:0] x_begin, x_end, y_begin, y_end;

  // Stage valids and load conditions; stage NSTG-1 is the output register.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;
  logic            in_fire;
  logic            in_dest;

  logic signed [awm_pkg::CENT_W-1:0] xc, yc;
  logic signed [awm_pkg::CENT_W-1:0] xc_next, yc_next;

  awm_pkg::stage_en_t                en;
  logic signed [awm_pkg::K_W-1:0]    kx, ky;
  logic signed [awm_pkg::K_W-1:0]    xb_s, xe_s, yb_s, ye_s;
  logic signed [awm_pkg::OUT_W-1:0]  source_x_next, source_y_next;
  logic                              inside_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_from_x      <= awm_pkg::COEF_ONE;
      x_from_y      <= '0;
      x_offset      <= '0;
      y_from_x      <= '0;
      y_from_y      <= awm_pkg::COEF_ONE;
      y_offset      <= '0;
      image_sizes   <= '0;
      window_bounds <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        awm_pkg::REG_X_FROM_X:      x_from_x      <= cfg_data[awm_pkg::COEF_W-1:0];
        awm_pkg::REG_X_FROM_Y:      x_from_y      <= cfg_data[awm_pkg::COEF_W-1:0];
        awm_pkg::REG_X_OFFSET:      x_offset      <= cfg_data[awm_pkg::OFF_W-1:0];
        awm_pkg::REG_Y_FROM_X:      y_from_x      <= cfg_data[awm_pkg::COEF_W-1:0];
        awm_pkg::REG_Y_FROM_Y:      y_from_y      <= cfg_data[awm_pkg::COEF_W-1:0];
        awm_pkg::REG_Y_OFFSET:      y_offset      <= cfg_data[awm_pkg::OFF_W-1:0];
        awm_pkg::REG_IMAGE_SIZES:   image_sizes   <= cfg_data;
        awm_pkg::REG_WINDOW_BOUNDS: window_bounds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dest_w  = awm_pkg::pack_field(image_sizes, 0);
    dest_h  = awm_pkg::pack_field(image_sizes, 1);
    src_w   = awm_pkg::pack_field(image_sizes, 2);
    src_h   = awm_pkg::pack_field(image_sizes, 3);
    x_begin = awm_pkg::pack_field(window_bounds, 0);
    x_end   = awm_pkg::pack_field(window_bounds, 1);
    y_begin = awm_pkg::pack_field(window_bounds, 2);
    y_end   = awm_pkg::pack_field(window_bounds, 3);
  end

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];
  assign in_fire  = in_valid && in_ready;
  assign in_dest  = (dest_x < dest_w) && (dest_y < dest_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_fire && in_dest;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Centering on half the destination size, taken at acceptance.
  always_comb begin
    xc_next = $signed({1'b0, dest_x}) - $signed({2'b00, dest_w[awm_pkg::COORD_BITS-1:1]});
    yc_next = $signed({1'b0, dest_y}) - $signed({2'b00, dest_h[awm_pkg::COORD_BITS-1:1]});
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_dest) begin
      xc <= xc_next;
      yc <= yc_next;
    end
  end

  always_comb begin
    en.prod  = rdy[1] && vld[0];
    en.lin   = rdy[2] && vld[1];
    en.vhi   = rdy[3] && vld[2];
    en.coord = rdy[4] && vld[3];
  end

  awm_axis u_axis_x (
    .clk      (clk),
    .en       (en),
    .ca       (x_from_x),
    .cb       (x_from_y),
    .off      (x_offset),
    .xc       (xc),
    .yc       (yc),
    .half_src ({1'b0, src_w[awm_pkg::COORD_BITS-1:1]}),
    .coord    (kx)
  );

  awm_axis u_axis_y (
    .clk      (clk),
    .en       (en),
    .ca       (y_from_x),
    .cb       (y_from_y),
    .off      (y_offset),
    .xc       (xc),
    .yc       (yc),
    .half_src ({1'b0, src_h[awm_pkg::COORD_BITS-1:1]}),
    .coord    (ky)
  );

  // Window test on the exact coordinates, then saturation for the output.
  always_comb begin
    xb_s = awm_pkg::K_W'(x_begin);
    xe_s = awm_pkg::K_W'(x_end);
    yb_s = awm_pkg::K_W'(y_begin);
    ye_s = awm_pkg::K_W'(y_end);
    inside_next = (kx >= xb_s) && (kx < xe_s) && (ky >= yb_s) && (ky < ye_s);

    if (kx > awm_pkg::K_HI) begin
      source_x_next = awm_pkg::OUT_W'(awm_pkg::K_HI);
    end else if (kx < awm_pkg::K_LO) begin
      source_x_next = awm_pkg::OUT_W'(awm_pkg::K_LO);
    end else begin
      source_x_next = kx[awm_pkg::OUT_W-1:0];
    end

    if (ky > awm_pkg::K_HI) begin
      source_y_next = awm_pkg::OUT_W'(awm_pkg::K_HI);
    end else if (ky < awm_pkg::K_LO) begin
      source_y_next = awm_pkg::OUT_W'(awm_pkg::K_LO);
    end else begin
      source_y_next = ky[awm_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1] && vld[NSTG-2]) begin
      source_x   <= source_x_next;
      source_y   <= source_y_next;
      inside_res <= inside_next;
    end
  end

  assign out_valid = vld[NSTG-1];

endmodule

`default_nettype wire

>>> rtl/core/awm_checker.sv
// Port-level checks for the affine warp address generator, bound to the top.
// Depends on awm_pkg for port widths and on the top level's port names.
`default_nettype none

module awm_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [awm_pkg::OUT_W-1:0]     source_x,
  input wire logic signed [awm_pkg::OUT_W-1:0]     source_y,
  input wire logic                                 inside_res
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // Input backpressure only comes from a stalled output with a full pipeline.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without an output stall");

  // A point inside the window is never negative and never saturated.
  a_inside_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> !source_x[awm_pkg::OUT_W-1] && !source_y[awm_pkg::OUT_W-1])
    else $error("inside point with negative coordinate");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(source_x) && $stable(source_y) && $stable(inside_res))
    else $error("result item changed while stalled");

endmodule

bind affine_warp_nearest_map_roi_top awm_checker u_awm_checker (.*);

`default_nettype wire

>>> tb/sv/affine_warp_nearest_map_roi_top_test.sv
// Self-checking testbench for the affine warp address generator: directed and random
// destination pixels checked against a fixed-point mapping kept in the bench.
// Depends on awm_pkg and affine_warp_nearest_map_roi_top.
`timescale 1ns / 1ps

module affine_warp_nearest_map_roi_top_test;

  localparam int LIMIT_CYCLES   = 300000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 150;
  localparam int HOLD_PERIOD    = 1500;
  localparam int RAND_PHASES    = 8;
  localparam int RAND_PER_PHASE = 212;
  localparam longint FIX_ONE = 64'sd1 <<< awm_pkg::FRAC_BITS;
  localparam longint SRC_MAX = (64'sd1 <<< awm_pkg::COORD_BITS) - 64'sd1;
  localparam longint SRC_MIN = -(64'sd1 <<< awm_pkg::COORD_BITS);
  localparam logic [awm_pkg::CFG_IDX_W-1:0] LAST_IDX = '1;

  typedef struct packed {
    logic [awm_pkg::COORD_BITS-1:0] x;
    logic [awm_pkg::COORD_BITS-1:0] y;
  } dest_pix_t;

  typedef struct packed {
    logic signed [awm_pkg::OUT_W-1:0] sx;
    logic signed [awm_pkg::OUT_W-1:0] sy;
    logic                             in_win;
  } src_pix_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [awm_pkg::COORD_BITS-1:0]      dest_x = '0;
  logic [awm_pkg::COORD_BITS-1:0]      dest_y = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [awm_pkg::OUT_W-1:0]    source_x;
  logic signed [awm_pkg::OUT_W-1:0]    source_y;
  logic                                inside_res;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [awm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [awm_pkg::CFG_W-1:0]           cfg_data = '0;

  dest_pix_t dest_pix_q[$];
  src_pix_t  src_expect_q[$];
  int        err_count = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;
  int        hold_left = 0;
  int        rx_cycles = 0;
  int        next_hold = 400;

  // Current register contents as the block should hold them.
  longint      m_xx, m_xy, m_xo, m_yx, m_yy, m_yo;
  logic [63:0] m_sizes, m_window;

  affine_warp_nearest_map_roi_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .source_x   (source_x),
    .source_y   (source_y),
    .inside_res (inside_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The linear part, then its sum with the offset, is truncated toward zero, as signed division does.
  function automatic longint warp_axis(input longint ca, input longint cb, input longint off,
                                       input longint xc, input longint yc,
                                       input longint half_src);
    longint lin, whole, shifted;
    lin = ca * xc + cb * yc;
    whole = lin / FIX_ONE;
    shifted = (whole * FIX_ONE + off) / FIX_ONE;
    return shifted + half_src;
  endfunction

  function automatic logic signed [awm_pkg::OUT_W-1:0] clamp_src(input longint v);
    if (v > SRC_MAX) v = SRC_MAX;
    else if (v < SRC_MIN) v = SRC_MIN;
    return awm_pkg::OUT_W'(v);
  endfunction

  function automatic logic map_to_source(input dest_pix_t p, output src_pix_t r);
    longint dx, dy, dw, dh, sw, sh, xb, xe, yb, ye, xc, yc, k, l;
    dx = longint'(p.x);
    dy = longint'(p.y);
    dw = longint'(m_sizes[0*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    dh = longint'(m_sizes[1*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    sw = longint'(m_sizes[2*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    sh = longint'(m_sizes[3*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    xb = longint'(m_window[0*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    xe = longint'(m_window[1*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    yb = longint'(m_window[2*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    ye = longint'(m_window[3*awm_pkg::COORD_BITS +: awm_pkg::COORD_BITS]);
    r = '0;
    if (dx >= dw || dy >= dh) return 1'b0;
    xc = dx - dw / 2;
    yc = dy - dh / 2;
    k = warp_axis(m_xx, m_xy, m_xo, xc, yc, sw / 2);
    l = warp_axis(m_yx, m_yy, m_yo, xc, yc, sh / 2);
    // The window test uses the unsaturated coordinates.
    r.in_win = (k >= xb) && (k < xe) && (l >= yb) && (l < ye);
    r.sx = clamp_src(k);
    r.sy = clamp_src(l);
    return 1'b1;
  endfunction

  function automatic logic [63:0] pack4(input logic [15:0] f0, input logic [15:0] f1,
                                        input logic [15:0] f2, input logic [15:0] f3);
    return {f3, f2, f1, f0};
  endfunction

  function automatic logic [63:0] pick_coef(input bit wild);
    if (wild) return {$urandom(), $urandom()};
    return 64'(longint'($urandom_range(0, 4 * 65536)) - 64'sd131072);
  endfunction

  function automatic logic [63:0] pick_offset(input bit wild);
    if (wild) return {$urandom(), $urandom()};
    return 64'(longint'($urandom_range(0, 1 << 23)) - 64'sd4194304);
  endfunction

  // Sender: a new item is offered only once the current one has been taken.
  always @(posedge clk) begin
    dest_pix_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (dest_pix_q.size() != 0 && (no_idle || $urandom_range(99) >= 15)) begin
        nxt = dest_pix_q.pop_front();
        in_valid <= 1'b1;
        dest_x <= nxt.x;
        dest_y <= nxt.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with a long hold-off now and then so that the pipeline backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycles = rx_cycles + 1;
      if (hold_left == 0 && in_valid && rx_cycles >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = rx_cycles + HOLD_PERIOD;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 15);
      end
    end
  end

  // Watches all three channels: register writes, accepted items and results.
  always @(posedge clk) begin
    src_pix_t want;
    dest_pix_t taken;
    if (rst) begin
      m_xx = 64'sd65536;
      m_xy = 0;
      m_xo = 0;
      m_yx = 0;
      m_yy = 64'sd65536;
      m_yo = 0;
      m_sizes = '0;
      m_window = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (src_expect_q.size() == 0) begin
          $error("unexpected result item: source_x %0d source_y %0d inside_res %0d",
                 source_x, source_y, inside_res);
          err_count++;
        end else begin
          want = src_expect_q.pop_front();
          if (source_x !== want.sx) begin
            $error("source_x: expected %0d, actual %0d", want.sx, source_x);
            err_count++;
          end
          if (source_y !== want.sy) begin
            $error("source_y: expected %0d, actual %0d", want.sy, source_y);
            err_count++;
          end
          if (inside_res !== want.in_win) begin
            $error("inside_res: expected %0d, actual %0d", want.in_win, inside_res);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        taken.x = dest_x;
        taken.y = dest_y;
        if (map_to_source(taken, want)) src_expect_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (awm_pkg::cfg_reg_t'(cfg_index))
          awm_pkg::REG_X_FROM_X: m_xx = longint'($signed(cfg_data[awm_pkg::COEF_W-1:0]));
          awm_pkg::REG_X_FROM_Y: m_xy = longint'($signed(cfg_data[awm_pkg::COEF_W-1:0]));
          awm_pkg::REG_X_OFFSET: m_xo = longint'($signed(cfg_data[awm_pkg::OFF_W-1:0]));
          awm_pkg::REG_Y_FROM_X: m_yx = longint'($signed(cfg_data[awm_pkg::COEF_W-1:0]));
          awm_pkg::REG_Y_FROM_Y: m_yy = longint'($signed(cfg_data[awm_pkg::COEF_W-1:0]));
          awm_pkg::REG_Y_OFFSET: m_yo = longint'($signed(cfg_data[awm_pkg::OFF_W-1:0]));
          awm_pkg::REG_IMAGE_SIZES:   m_sizes = cfg_data;
          awm_pkg::REG_WINDOW_BOUNDS: m_window = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [awm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [awm_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register plus one index past the list, which must be ignored.
  task automatic write_all(input logic [63:0] a0, input logic [63:0] a1,
                           input logic [63:0] a2, input logic [63:0] a3,
                           input logic [63:0] a4, input logic [63:0] a5,
                           input logic [63:0] sizes, input logic [63:0] window);
    write_reg(awm_pkg::REG_X_FROM_X, a0);
    write_reg(awm_pkg::REG_X_FROM_Y, a1);
    write_reg(awm_pkg::REG_X_OFFSET, a2);
    write_reg(awm_pkg::REG_Y_FROM_X, a3);
    write_reg(awm_pkg::REG_Y_FROM_Y, a4);
    write_reg(awm_pkg::REG_Y_OFFSET, a5);
    write_reg(awm_pkg::REG_IMAGE_SIZES, sizes);
    write_reg(awm_pkg::REG_WINDOW_BOUNDS, window);
    write_reg(awm_pkg::CFG_IDX_W'($urandom_range(awm_pkg::REG_WINDOW_BOUNDS + 1, LAST_IDX)),
              {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
  endtask

  // Idle is judged between edges, once every process of the last edge has run.
  task automatic settle();
    do @(negedge clk);
    while (dest_pix_q.size() != 0 || in_valid || src_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pix(input int x, input int y);
    dest_pix_t p;
    p.x = awm_pkg::COORD_BITS'(x);
    p.y = awm_pkg::COORD_BITS'(y);
    dest_pix_q.push_back(p);
  endtask

  initial begin
    int p, n, mode;
    logic [15:0] dw, dh, sw, sh;
    logic [63:0] win;
    bit wild;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Straight after reset all sizes are zero, so every item is dropped.
    queue_pix(0, 0);
    queue_pix(65535, 65535);
    queue_pix(5, 7);

    // Identity map from reset, only sizes and window written.
    settle();
    write_reg(awm_pkg::REG_IMAGE_SIZES, pack4(16'd64, 16'd48, 16'd64, 16'd48));
    write_reg(awm_pkg::REG_WINDOW_BOUNDS, pack4(16'd0, 16'd64, 16'd0, 16'd48));
    cfg_valid <= 1'b0;
    queue_pix(0, 0);
    queue_pix(63, 47);
    queue_pix(64, 0);
    queue_pix(0, 48);
    queue_pix(32, 24);
    queue_pix(17, 5);

    // Extreme coefficients and offsets on the largest images: saturates both ways.
    settle();
    write_all(64'sd8388607, -64'sd8388608, 64'sd2147483647,
              -64'sd8388608, 64'sd8388607, -64'sd2147483648,
              pack4(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
              pack4(16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
    queue_pix(0, 0);
    queue_pix(65534, 65534);
    queue_pix(65534, 0);
    queue_pix(0, 65534);
    queue_pix(65535, 3);
    queue_pix(3, 65535);

    // Offset-only map to a negative column, with an empty row range.
    settle();
    write_all(64'd0, 64'd0, -64'sd327681, 64'd0, 64'd0, 64'sd196615,
              pack4(16'd8, 16'd8, 16'd0, 16'd0), pack4(16'd0, 16'd10, 16'd5, 16'd5));
    queue_pix(0, 0);
    queue_pix(7, 7);
    queue_pix(1, 6);
    queue_pix(8, 1);

    // Fractional coefficients exercise truncation toward zero; the window's x range is inverted.
    settle();
    write_all(64'sd98304, -64'sd32769, -64'sd32768, -64'sd98305, 64'sd32767, 64'sd65535,
              pack4(16'd16, 16'd16, 16'd20, 16'd20), pack4(16'd15, 16'd5, 16'd0, 16'd20));
    queue_pix(0, 0);
    queue_pix(1, 3);
    queue_pix(15, 15);
    queue_pix(7, 9);

    for (p = 0; p < RAND_PHASES; p++) begin
      mode = p % 4;
      wild = (mode == 2);
      if (mode == 3) begin
        dw = 16'($urandom_range(1, 65535));
        dh = 16'($urandom_range(1, 65535));
        sw = 16'($urandom_range(0, 65535));
        sh = 16'($urandom_range(0, 65535));
      end else begin
        dw = 16'($urandom_range(1, 200));
        dh = 16'($urandom_range(1, 200));
        sw = 16'($urandom_range(1, 512));
        sh = 16'($urandom_range(1, 512));
      end
      if (mode == 1) begin
        win = {$urandom(), $urandom()};
      end else begin
        win = pack4(16'($urandom_range(0, sw / 2)), 16'($urandom_range(sw / 2, sw)),
                    16'($urandom_range(0, sh / 2)), 16'($urandom_range(sh / 2, sh)));
      end
      settle();
      no_idle = (p == 2);
      write_all(pick_coef(wild), pick_coef(wild), pick_offset(wild),
                pick_coef(wild), pick_coef(wild), pick_offset(wild),
                pack4(dw, dh, sw, sh), win);
      n = 0;
      while (n < RAND_PER_PHASE) begin
        if ($urandom_range(99) < 88) begin
          queue_pix($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
          n++;
        end else if ($urandom_range(1, 0) == 1) begin
          queue_pix($urandom_range(dw, 65535), $urandom_range(0, 65535));
        end else begin
          queue_pix($urandom_range(0, 65535), $urandom_range(dh, 65535));
        end
      end
    end

    settle();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/awm_pkg.sv
rtl/core/awm_axis.sv
rtl/core/affine_warp_nearest_map_roi_top.sv
rtl/core/awm_checker.sv
tb/sv/affine_warp_nearest_map_roi_top_test.sv
